// ===== design/packet_frame_encoder_unit_assert.svh =====
// Assertion macros shared by the framer modules. Each macro expects clk and rst_n in scope.
`ifndef PACKET_FRAME_ENCODER_UNIT_ASSERT_SVH
`define PACKET_FRAME_ENCODER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PEF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("framer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PEF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("framer assertion failed");

`endif

// ===== design/pef_pkg.sv =====
`default_nettype none

package pef_pkg;

  typedef struct packed {
    logic [1:0]  ack_kind;
    logic [7:0]  command;
    logic [2:0]  payload_size;
    logic [31:0] payload;
  } pef_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } pef_out_t;

  // Message kinds; the unused code is handled as a new command.
  localparam logic [1:0] KIND_NEW = 2'd0;
  localparam logic [1:0] KIND_ACK = 2'd1;
  localparam logic [1:0] KIND_NAK = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_START  = 3'd0;
  localparam logic [2:0] REG_END    = 3'd1;
  localparam logic [2:0] REG_ESCAPE = 3'd2;
  localparam logic [2:0] REG_ACK    = 3'd3;
  localparam logic [2:0] REG_NAK    = 3'd4;

  // Source of the next output word.
  localparam logic [2:0] SEL_START = 3'd0;
  localparam logic [2:0] SEL_CODE  = 3'd1;
  localparam logic [2:0] SEL_CMD   = 3'd2;
  localparam logic [2:0] SEL_ESC   = 3'd3;
  localparam logic [2:0] SEL_PAY   = 3'd4;
  localparam logic [2:0] SEL_CSUM  = 3'd5;
  localparam logic [2:0] SEL_END   = 3'd6;

  typedef struct packed {
    logic       load;
    logic       emit;
    logic       last;
    logic       advance;
    logic [2:0] sel;
  } pef_cmd_t;

  typedef struct packed {
    logic out_free;
    logic is_ack;
    logic cmd_is_nak;
    logic size_zero;
    logic idx_zero;
    logic pay_ctrl;
    logic csum_ctrl;
  } pef_stat_t;

endpackage

`default_nettype wire

// ===== design/pef_ctrl.sv =====
`default_nettype none
`include "packet_frame_encoder_unit_assert.svh"

module pef_ctrl import pef_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  pef_stat_t stat,
  output pef_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_START    = 4'd1;
  localparam logic [3:0] S_CODE     = 4'd2;
  localparam logic [3:0] S_CMD      = 4'd3;
  localparam logic [3:0] S_PAY      = 4'd4;
  localparam logic [3:0] S_PAY_RAW  = 4'd5;
  localparam logic [3:0] S_CSUM     = 4'd6;
  localparam logic [3:0] S_CSUM_RAW = 4'd7;
  localparam logic [3:0] S_END      = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_START;
          state_nxt = stat.is_ack ? S_CODE : S_CMD;
        end
      end
      S_CODE: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_CODE;
          state_nxt = stat.cmd_is_nak ? S_END : S_CMD;
        end
      end
      S_CMD: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_CMD;
          state_nxt = (stat.is_ack || stat.size_zero) ? S_END : S_PAY;
        end
      end
      S_PAY: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.pay_ctrl) begin
            cmd.sel   = SEL_ESC;
            state_nxt = S_PAY_RAW;
          end else begin
            cmd.sel     = SEL_PAY;
            cmd.advance = 1'b1;
            state_nxt   = stat.idx_zero ? S_CSUM : S_PAY;
          end
        end
      end
      S_PAY_RAW: begin
        if (stat.out_free) begin
          cmd.emit    = 1'b1;
          cmd.sel     = SEL_PAY;
          cmd.advance = 1'b1;
          state_nxt   = stat.idx_zero ? S_CSUM : S_PAY;
        end
      end
      S_CSUM: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.csum_ctrl) begin
            cmd.sel   = SEL_ESC;
            state_nxt = S_CSUM_RAW;
          end else begin
            cmd.sel   = SEL_CSUM;
            state_nxt = S_END;
          end
        end
      end
      S_CSUM_RAW: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = SEL_CSUM;
          state_nxt = S_END;
        end
      end
      S_END: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.last  = 1'b1;
          cmd.sel   = SEL_END;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `PEF_ASSERT_NEXT(a_load_starts_frame, in_valid && in_ready, state_r == S_START)
  `PEF_ASSERT_SAME(a_emit_needs_room, cmd.emit, stat.out_free)
  `PEF_ASSERT_SAME(a_last_is_end, cmd.last, cmd.emit && (cmd.sel == SEL_END))
  `PEF_ASSERT_SAME(a_idle_silent, state_r == S_IDLE, !cmd.emit && !cmd.advance)

endmodule

`default_nettype wire

// ===== design/pef_dp.sv =====
`default_nettype none
`include "packet_frame_encoder_unit_assert.svh"

module pef_dp import pef_pkg::*; #(
  parameter int MAX_PAYLOAD_BYTES = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  pef_in_t    in_data,
  output pef_out_t   out_data,
  output logic       out_valid,
  input  logic       out_ready,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  pef_cmd_t   cmd,
  output pef_stat_t  stat
);

  localparam logic [3:0] MAX_W = 4'(MAX_PAYLOAD_BYTES);

  logic [7:0]  start_code_r, end_code_r, escape_code_r, ack_code_r, nak_code_r;
  logic        is_ack_r, is_nak_r, size_zero_r;
  logic [7:0]  cmd_r, sum_r;
  logic [2:0]  idx_r;
  logic [31:0] payload_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r, out_valid_r;

  logic [2:0]  size_clamped;
  logic [7:0]  cur_byte, csum, emit_byte;

  // Payload sizes above the limit are clamped before the frame is built.
  assign size_clamped = ({1'b0, in_data.payload_size} > MAX_W) ? MAX_W[2:0]
                                                               : in_data.payload_size;

  // Indexes beyond the 32-bit payload field read as zero.
  assign cur_byte = idx_r[2] ? 8'h00 : payload_r[{idx_r[1:0], 3'b000} +: 8];
  assign csum     = 8'h00 - sum_r;

  assign stat.out_free   = !out_valid_r || out_ready;
  assign stat.is_ack     = is_ack_r;
  assign stat.cmd_is_nak = (cmd_r == nak_code_r);
  assign stat.size_zero  = size_zero_r;
  assign stat.idx_zero   = (idx_r == 3'd0);
  assign stat.pay_ctrl   = (cur_byte == start_code_r) || (cur_byte == end_code_r) ||
                           (cur_byte == escape_code_r);
  assign stat.csum_ctrl  = (csum == start_code_r) || (csum == end_code_r) ||
                           (csum == escape_code_r);

  always_comb begin
    unique case (cmd.sel)
      SEL_START: emit_byte = start_code_r;
      SEL_CODE:  emit_byte = is_nak_r ? nak_code_r : ack_code_r;
      SEL_CMD:   emit_byte = cmd_r;
      SEL_ESC:   emit_byte = escape_code_r;
      SEL_PAY:   emit_byte = cur_byte;
      SEL_CSUM:  emit_byte = csum;
      SEL_END:   emit_byte = end_code_r;
      default:   emit_byte = end_code_r;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_code_r  <= 8'd2;
      end_code_r    <= 8'd3;
      escape_code_r <= 8'd27;
      ack_code_r    <= 8'd6;
      nak_code_r    <= 8'd21;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START:  start_code_r  <= cfg_data;
        REG_END:    end_code_r    <= cfg_data;
        REG_ESCAPE: escape_code_r <= cfg_data;
        REG_ACK:    ack_code_r    <= cfg_data;
        REG_NAK:    nak_code_r    <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Message capture, payload walk and running sum.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_ack_r    <= (in_data.ack_kind == KIND_ACK) || (in_data.ack_kind == KIND_NAK);
      is_nak_r    <= (in_data.ack_kind == KIND_NAK);
      cmd_r       <= in_data.command;
      payload_r   <= in_data.payload;
      size_zero_r <= (size_clamped == 3'd0);
      idx_r       <= size_clamped - 3'd1;
      sum_r       <= 8'h00;
    end else if (cmd.advance) begin
      idx_r <= idx_r - 3'd1;
      sum_r <= sum_r + cur_byte;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= cmd.last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data.out_byte  = out_byte_r;
  assign out_data.last_byte = out_last_r;

  `PEF_ASSERT_NEXT(a_load_clears_sum, cmd.load, sum_r == 8'h00)

endmodule

`default_nettype wire

// ===== design/packet_frame_encoder_unit.sv =====
`default_nettype none

// Framer for one message per input word: emits start code, the ack or nak code and command
// (the command is left out when it equals the nak code), or the command, escaped payload bytes
// from the highest index down and an escaped checksum (both only for a non-empty payload), then
// the end code, flagged as last. One output word leaves per cycle while the output side is
// ready. The sequencer handles one message at a time and takes the next once the end
// code has been registered; the registered output word lets that last byte wait for the
// consumer meanwhile.

module packet_frame_encoder_unit import pef_pkg::*; #(
  parameter int MAX_PAYLOAD_BYTES = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  pef_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output pef_out_t   out_data,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  pef_cmd_t  cmd;
  pef_stat_t stat;

  pef_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pef_dp #(
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire

// ===== test/packet_frame_encoder_unit_frame_checker.sv =====
`default_nettype none

module packet_frame_encoder_unit_frame_checker import pef_pkg::*; #(
  parameter int MAX_PAYLOAD_BYTES = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  pef_in_t    in_data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  pef_out_t   out_data,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         mismatches,
  output int         words_due
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] RESET_START  = 8'd2;
  localparam logic [7:0] RESET_END    = 8'd3;
  localparam logic [7:0] RESET_ESCAPE = 8'd27;
  localparam logic [7:0] RESET_ACK    = 8'd6;
  localparam logic [7:0] RESET_NAK    = 8'd21;

  logic [7:0] start_code;
  logic [7:0] end_code;
  logic [7:0] escape_code;
  logic [7:0] ack_code;
  logic [7:0] nak_code;

  // Bytes of the frames in flight, oldest first.
  pef_out_t frame_bytes_due[$];

  function automatic logic is_control(logic [7:0] b);
    return b == start_code || b == end_code || b == escape_code;
  endfunction

  task automatic queue_byte(logic [7:0] b, logic last);
    pef_out_t w;
    w.out_byte  = b;
    w.last_byte = last;
    frame_bytes_due.push_back(w);
  endtask

  task automatic queue_stuffed(logic [7:0] b);
    if (is_control(b)) queue_byte(escape_code, 1'b0);
    queue_byte(b, 1'b0);
  endtask

  task automatic predict_frame(pef_in_t msg);
    int used;
    logic [7:0] sum;
    logic [7:0] b;
    queue_byte(start_code, 1'b0);
    if (msg.ack_kind == KIND_ACK || msg.ack_kind == KIND_NAK) begin
      // Neither the code nor the command is stuffed in an acknowledge.
      queue_byte(msg.ack_kind == KIND_ACK ? ack_code : nak_code, 1'b0);
      if (msg.command != nak_code) queue_byte(msg.command, 1'b0);
    end else begin
      queue_byte(msg.command, 1'b0);
      used = (int'(msg.payload_size) > MAX_PAYLOAD_BYTES) ? MAX_PAYLOAD_BYTES
                                                          : int'(msg.payload_size);
      if (used != 0) begin
        sum = 8'h00;
        for (int i = used - 1; i >= 0; i--) begin
          b = (i < 4) ? msg.payload[8*i +: 8] : 8'h00;
          sum = sum + b;
          queue_stuffed(b);
        end
        queue_stuffed(8'h00 - sum);
      end
    end
    queue_byte(end_code, 1'b1);
  endtask

  task automatic check_word(pef_out_t got);
    pef_out_t want;
    if (frame_bytes_due.size() == 0) begin
      mismatches++;
      $display("%0t: word byte %h last %b arrived with nothing expected",
               $time, got.out_byte, got.last_byte);
    end else begin
      want = frame_bytes_due.pop_front();
      if (got.out_byte !== want.out_byte) begin
        mismatches++;
        $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, got.out_byte);
      end
      if (got.last_byte !== want.last_byte) begin
        mismatches++;
        $display("%0t: last_byte expected %b actual %b", $time, want.last_byte,
                 got.last_byte);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start_code  = RESET_START;
      end_code    = RESET_END;
      escape_code = RESET_ESCAPE;
      ack_code    = RESET_ACK;
      nak_code    = RESET_NAK;
      frame_bytes_due.delete();
      mismatches = 0;
      words_due  = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START:  start_code  = cfg_data;
          REG_END:    end_code    = cfg_data;
          REG_ESCAPE: escape_code = cfg_data;
          REG_ACK:    ack_code    = cfg_data;
          REG_NAK:    nak_code    = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_frame(in_data);
      if (out_valid && out_ready) check_word(out_data);
      words_due = frame_bytes_due.size();
    end
  end

endmodule

`default_nettype wire

// ===== test/packet_frame_encoder_unit_tb.sv =====
`default_nettype none

module packet_frame_encoder_unit_tb import pef_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CYCLE_LIMIT      = 400000;
  localparam int         SETTLE_CYCLES    = 16;
  localparam int         RANDOM_PER_PHASE = 75;
  localparam int         PHASES           = 6;
  localparam logic [1:0] KIND_SPARE       = 2'd3;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  pef_in_t    in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  pef_out_t   out_data;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_START;
  logic [7:0] cfg_data = 8'h00;

  int mismatches;
  int words_due;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // The codes the block holds, kept here to aim the stimulus at them.
  logic [7:0] code_start = 8'd2;
  logic [7:0] code_end   = 8'd3;
  logic [7:0] code_esc   = 8'd27;
  logic [7:0] code_ack   = 8'd6;
  logic [7:0] code_nak   = 8'd21;

  packet_frame_encoder_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  packet_frame_encoder_unit_frame_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .words_due  (words_due)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic pef_in_t make_msg(logic [1:0] kind, logic [7:0] cmd, logic [2:0] size,
                                       logic [31:0] pay);
    pef_in_t m;
    m.ack_kind     = kind;
    m.command      = cmd;
    m.payload_size = size;
    m.payload      = pay;
    return m;
  endfunction

  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 5))
      0:       return code_start;
      1:       return code_end;
      2:       return code_esc;
      3:       return code_ack;
      4:       return code_nak;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pef_in_t random_msg();
    pef_in_t m;
    int unsigned r;
    int used;
    logic [7:0] partial;
    r = $urandom_range(0, 99);
    m.ack_kind = (r < 60) ? KIND_NEW : (r < 75) ? KIND_ACK : (r < 90) ? KIND_NAK
                                                                       : KIND_SPARE;
    m.command = ($urandom_range(0, 3) == 0) ? code_nak : pick_code();
    m.payload_size = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                 : 3'($urandom_range(0, 4));
    if ($urandom_range(0, 4) == 0) begin
      m.payload = $urandom;
    end else begin
      for (int i = 0; i < 4; i++)
        m.payload[8*i +: 8] = ($urandom_range(0, 1) != 0) ? pick_code() : 8'($urandom);
    end
    // Now and then force the checksum onto one of the codes through the lowest byte.
    used = (m.payload_size > 3'd4) ? 4 : int'(m.payload_size);
    if (used != 0 && m.ack_kind != KIND_ACK && m.ack_kind != KIND_NAK &&
        $urandom_range(0, 3) == 0) begin
      partial = 8'h00;
      for (int i = 1; i < used; i++) partial = partial + m.payload[8*i +: 8];
      m.payload[7:0] = 8'h00 - pick_code() - partial;
    end
    return m;
  endfunction

  task automatic send_msg(pef_in_t m, bit hold_off);
    if (hold_off) begin
      in_valid <= 1'b0;
      do @(negedge clk); while (words_due != 0);
    end else if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= m;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    while (words_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  task automatic set_codes(logic [7:0] s, logic [7:0] e, logic [7:0] x, logic [7:0] a,
                           logic [7:0] n);
    write_reg(REG_START, s);
    write_reg(REG_END, e);
    write_reg(REG_ESCAPE, x);
    write_reg(REG_ACK, a);
    write_reg(REG_NAK, n);
    // Writes to the unused indexes must leave every code alone.
    for (int i = int'(REG_NAK) + 1; i < 8; i++) write_reg(3'(i), 8'($urandom));
    cfg_we     <= 1'b0;
    code_start = s;
    code_end   = e;
    code_esc   = x;
    code_ack   = a;
    code_nak   = n;
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int phase = 0; phase < PHASES; phase++) begin
      send_idle_pct = (phase < 2) ? 37 : (phase < 4) ? 70 : 0;
      recv_idle_pct = (phase < 2) ? 70 : (phase < 4) ? 37 : 0;
      if (phase > 0) begin
        in_valid <= 1'b0;
        drain();
        case (phase)
          1:       set_codes(8'h00, 8'hFF, 8'h80, 8'h00, 8'hFF);
          2:       set_codes(8'hFF, 8'h00, 8'h01, 8'hFF, 8'h00);
          3:       set_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom));
          4:       set_codes(8'h7E, 8'h7E, 8'h7D, 8'h7E, 8'h7D);
          default: set_codes(8'd2, 8'd3, 8'd27, 8'd6, 8'd21);
        endcase
      end else begin
        send_msg(make_msg(KIND_ACK, 8'h00, 3'd0, 32'h0), 1'b0);
        send_msg(make_msg(KIND_ACK, code_nak, 3'd0, 32'h0), 1'b0);
        send_msg(make_msg(KIND_NAK, 8'hFF, 3'd0, 32'h0), 1'b0);
        send_msg(make_msg(KIND_NAK, code_nak, 3'd0, 32'h0), 1'b0);
        send_msg(make_msg(KIND_ACK, code_start, 3'd7, 32'hFFFF_FFFF), 1'b0);
        send_msg(make_msg(KIND_NAK, code_esc, 3'd4, {code_esc, code_end, code_start, 8'h00}),
                 1'b0);
        send_msg(make_msg(KIND_NEW, 8'hFF, 3'd0, 32'hDEAD_BEEF), 1'b0);
        send_msg(make_msg(KIND_NEW, code_esc, 3'd0, 32'h0), 1'b0);
        send_msg(make_msg(KIND_NEW, 8'h00, 3'd1, 32'h0), 1'b0);
        send_msg(make_msg(KIND_NEW, 8'h5A, 3'd4, 32'hFFFF_FFFF), 1'b0);
        send_msg(make_msg(KIND_NEW, 8'h33, 3'd4, {code_esc, code_end, code_start, 8'h80}),
                 1'b0);
        send_msg(make_msg(KIND_NEW, 8'h12, 3'd7, 32'h1234_5678), 1'b0);
        send_msg(make_msg(KIND_NEW, 8'h34, 3'd5, 32'h0203_1B00), 1'b0);
        send_msg(make_msg(KIND_SPARE, 8'hC3, 3'd2, 32'hA5A5_5A5A), 1'b0);
        send_msg(make_msg(KIND_SPARE, 8'hFF, 3'd7, 32'hFFFF_FFFF), 1'b0);
        send_msg(make_msg(KIND_NEW, 8'h01, 3'd1, {24'h0, 8'h00 - code_esc}), 1'b0);
        send_msg(make_msg(KIND_NEW, 8'h02, 3'd1, {24'h0, 8'h00 - code_start}), 1'b0);
        send_msg(make_msg(KIND_NEW, 8'h03, 3'd2, {16'h0, 8'h00 - code_end - 8'h01, 8'h01}),
                 1'b0);
        send_msg(make_msg(KIND_NEW, 8'h04, 3'd3, 32'hFF00_FFFF), 1'b0);
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++)
        send_msg(random_msg(), (n % 40) == 39);
    end

    in_valid <= 1'b0;
    drain();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
